/* rtl/core/fpsqrt_pkg.sv */
// Shared constants for the fixed-point square root pipeline.
// No dependencies.
`default_nettype none

package fpsqrt_pkg;

    localparam int OPERAND_W = 32;   // signed fixed-point operand
    localparam int ROOT_W    = 24;   // unsigned fixed-point root

endpackage

`default_nettype wire

/* rtl/core/fpsqrt_stage.sv */
// One pipeline stage of the digit-by-digit square root: settles one root bit.
// Standalone; instantiated by fixed_point_square_root.
`default_nettype none

module fpsqrt_stage #(
    parameter int REM_W  = 48,   // remainder width (twice the root width)
    parameter int Q_W    = 24,   // root width
    parameter int BIT_K  = 0     // this stage tests the trial bit 4^BIT_K
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [REM_W-1:0] in_rem,
    input  wire logic [Q_W-1:0]   in_q,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [REM_W-1:0] out_rem,
    output logic      [Q_W-1:0]   out_q
);

    logic             valid_reg;
    logic [REM_W-1:0] rem_reg;
    logic [Q_W-1:0]   q_reg;
    logic [REM_W-1:0] trial;
    logic             take;
    logic [REM_W-1:0] rem_next;
    logic [Q_W-1:0]   q_next;

    // trial = (4q + 1) * 4^k
    always_comb begin
        trial    = REM_W'({in_q, 2'b01}) << (2 * BIT_K);
        take     = (in_rem >= trial);
        rem_next = take ? (in_rem - trial) : in_rem;
        q_next   = {in_q[Q_W-2:0], take};
    end

    // stage holds an item unless the next one can take it
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_q     = q_reg;

endmodule

`default_nettype wire

/* rtl/core/fixed_point_square_root.sv */
// Top level of the fixed-point square root pipeline.
// Uses fpsqrt_pkg and fpsqrt_stage.
`default_nettype none

// Fixed-point square root. Each item carries a signed 32-bit operand with
// FRACTION_BITS fraction bits; the result is the floor square root in the
// same format, taken as floor(sqrt(operand * 2^FRACTION_BITS)), low 24 bits.
// A negative operand gives zero. The pipeline has one stage per root bit:
// NSTEP = (32 + FRACTION_BITS) / 2 stages (24 at the default), each doing a
// single compare-and-subtract on a 2*NSTEP-bit remainder; each stage is
// registered. Throughput is one item per cycle while m_ready is high.
// Every stage has its own valid bit and accepts whenever it is empty or
// its successor accepts, so bubbles close up during an output stall and the
// input keeps being taken until the pipe is full. No state survives an item.

module fixed_point_square_root #(
    parameter int FRACTION_BITS = 16   // 0 .. 30
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [fpsqrt_pkg::OPERAND_W-1:0] s_operand,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic             [fpsqrt_pkg::ROOT_W-1:0]    m_root
);

    // root bits needed for a (31 + FRACTION_BITS)-bit nonnegative value
    localparam int NSTEP = (fpsqrt_pkg::OPERAND_W + FRACTION_BITS) / 2;
    localparam int REM_W = 2 * NSTEP;

    logic             valid_w [0:NSTEP];
    logic             ready_w [0:NSTEP];
    logic [REM_W-1:0] rem_w   [0:NSTEP-1];
    logic [NSTEP-1:0] q_w     [0:NSTEP];

    // Widen and scale; a negative operand enters as zero and yields zero.
    assign rem_w[0] = s_operand[fpsqrt_pkg::OPERAND_W-1] ? '0 :
                      REM_W'(s_operand[fpsqrt_pkg::OPERAND_W-2:0]) << FRACTION_BITS;

    assign q_w[0]     = '0;
    assign valid_w[0] = s_valid;
    assign s_ready    = ready_w[0];

    // stage i settles root bit NSTEP-1-i (trial bit 4^(NSTEP-1-i))
    for (genvar i = 0; i < NSTEP; i++) begin : g_stage
        if (i < NSTEP - 1) begin : g_mid
            fpsqrt_stage #(
                .REM_W (REM_W),
                .Q_W   (NSTEP),
                .BIT_K (NSTEP - 1 - i)
            ) u_stage (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (valid_w[i]),
                .in_ready  (ready_w[i]),
                .in_rem    (rem_w[i]),
                .in_q      (q_w[i]),
                .out_valid (valid_w[i+1]),
                .out_ready (ready_w[i+1]),
                .out_rem   (rem_w[i+1]),
                .out_q     (q_w[i+1])
            );
        end else begin : g_last
            // final remainder is not needed downstream
            fpsqrt_stage #(
                .REM_W (REM_W),
                .Q_W   (NSTEP),
                .BIT_K (0)
            ) u_stage (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (valid_w[i]),
                .in_ready  (ready_w[i]),
                .in_rem    (rem_w[i]),
                .in_q      (q_w[i]),
                .out_valid (valid_w[i+1]),
                .out_ready (ready_w[i+1]),
                .out_rem   (),
                .out_q     (q_w[i+1])
            );
        end
    end

    // last stage register is the output register
    assign m_valid        = valid_w[NSTEP];
    assign ready_w[NSTEP] = m_ready;
    assign m_root         = fpsqrt_pkg::ROOT_W'(q_w[NSTEP]);

endmodule

`default_nettype wire
